// ----- design/length_prefixed_frame_receiver_defines.svh -----
// Assertion macros for the frame receiver
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define LPFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lpfr: same-cycle check failed");
// Next-cycle implication, checked outside reset
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lpfr: next-cycle check failed");
`else
`define LPFR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/lpfr_pkg.sv -----
package lpfr_pkg;

  // Frame buffer geometry
  localparam int BufferBytes = 64;
  localparam int AddrW       = $clog2(BufferBytes);
  localparam int HeaderBytes = 3;
  localparam int MinLen      = 2;
  localparam int MaxLen      = BufferBytes - 2;

  // Field widths
  localparam int ByteW = 8;
  localparam int PosW  = 6;
  localparam int LenW  = 6;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegEnable    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegStartByte = 1'd1;
  localparam logic [ByteW-1:0]   StartByteRst = 8'hAA;

endpackage

// ----- design/lpfr_if.sv -----
// Received byte channel
interface lpfr_rx_if import lpfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_value;

  modport source (output valid, output rx_value, input ready);
  modport sink   (input valid, input rx_value, output ready);
endinterface

// Verified frame byte channel
interface lpfr_res_if import lpfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_value;
  logic [PosW-1:0]  position;
  logic [LenW-1:0]  frame_length;
  logic             last;

  modport source (output valid, output out_value, output position, output frame_length,
                  output last, input ready);
  modport sink   (input valid, input out_value, input position, input frame_length,
                  input last, output ready);
endinterface

// ----- design/lpfr_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data
module lpfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/length_prefixed_frame_receiver.sv -----
// Length-prefixed frame receiver. Received bytes are accepted whenever no frame is read
// out: while enabled, the block hunts for the start byte, then takes length L (2..BufferBytes-2),
// the checksum, the type byte and the data bytes, and writes the payload into a frame
// buffer RAM. When L+2 bytes have arrived and the checksum equals the inverted 8-bit sum
// of type and data, the L-1 stored bytes are read back one at a time (RAM read, then
// output register load), and the receive side stays blocked until the last read is issued,
// which takes longer while results are held off; a bad frame emits nothing. Bytes taken
// while disabled are dropped.
`include "length_prefixed_frame_receiver_defines.svh"

module length_prefixed_frame_receiver import lpfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lpfr_rx_if.sink             rx_i,
  lpfr_res_if.source          res_o
);

  typedef enum logic {S_RX, S_EMIT} state_e;

  state_e           state_q, state_d;
  logic             enable_q, enable_d;
  logic [ByteW-1:0] start_q, start_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] len_q, len_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [AddrW-1:0] emit_idx_q, emit_idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic [AddrW-1:0] rd_pos_q, rd_pos_d;
  logic             rd_last_q, rd_last_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q, out_data_d;
  logic [PosW-1:0]  out_pos_q, out_pos_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic             out_last_q, out_last_d;

  logic             in_fire, res_fire;
  logic [ByteW-1:0] rx_byte;
  logic [ByteW-1:0] sum_new;
  logic [AddrW:0]   cnt_inc;
  logic             frame_done;
  logic             ram_we, rd_en, rd_is_last;
  logic [AddrW-1:0] rd_addr;
  logic [ByteW-1:0] ram_rdata;

  assign rx_byte  = rx_i.rx_value;
  assign in_fire  = rx_i.valid && rx_i.ready;
  assign res_fire = out_valid_q && res_o.ready;

  assign rx_i.ready         = (state_q == S_RX);
  assign res_o.valid        = out_valid_q;
  assign res_o.out_value    = out_data_q;
  assign res_o.position     = out_pos_q;
  assign res_o.frame_length = out_len_q;
  assign res_o.last         = out_last_q;

  // Payload byte bookkeeping
  assign sum_new    = sum_q + rx_byte;
  assign cnt_inc    = {1'b0, cnt_q} + (AddrW+1)'(1);
  assign frame_done = (cnt_inc == ({1'b0, len_q} + (AddrW+1)'(2)));
  assign ram_we     = in_fire && enable_q && (cnt_q >= AddrW'(HeaderBytes));

  // Read-out addressing: one read in flight, issued only when the output register frees
  assign rd_en      = (state_q == S_EMIT) && !rd_pend_q && (!out_valid_q || res_fire);
  assign rd_addr    = emit_idx_q + AddrW'(HeaderBytes);
  assign rd_is_last = (emit_idx_q == (len_q - AddrW'(2)));

  lpfr_ram #(
    .Width (ByteW),
    .Depth (BufferBytes)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (rx_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    enable_d    = enable_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    chk_d       = chk_q;
    sum_d       = sum_q;
    emit_idx_d  = emit_idx_q;
    rd_pend_d   = 1'b0;
    rd_pos_d    = rd_pos_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_pos_d   = out_pos_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;

    // Register writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEnable:    enable_d = cfg_data_i[0];
        RegStartByte: start_d  = cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end

    // Frame reception: drop bytes while disabled
    if (in_fire && enable_q) begin
      case (cnt_q)
        AddrW'(0): begin
          if (rx_byte == start_q) begin
            cnt_d = AddrW'(1);
          end
        end
        AddrW'(1): begin
          if (({1'b0, rx_byte} > (ByteW+1)'(MaxLen)) ||
              ({1'b0, rx_byte} < (ByteW+1)'(MinLen))) begin
            cnt_d = '0;
            len_d = '0;
          end else begin
            len_d = rx_byte[AddrW-1:0];
            cnt_d = AddrW'(2);
          end
        end
        AddrW'(2): begin
          chk_d = rx_byte;
          sum_d = '0;
          cnt_d = AddrW'(3);
        end
        default: begin
          sum_d = sum_new;
          cnt_d = cnt_inc[AddrW-1:0];
          if (frame_done) begin
            cnt_d = '0;
            if (~sum_new == chk_q) begin
              state_d    = S_EMIT;
              emit_idx_d = '0;
            end
          end
        end
      endcase
    end

    // Advance the read-out
    if (rd_en) begin
      rd_pend_d  = 1'b1;
      rd_pos_d   = emit_idx_q;
      rd_last_d  = rd_is_last;
      emit_idx_d = emit_idx_q + AddrW'(1);
      if (rd_is_last) begin
        state_d = S_RX;
      end
    end

    // Output register: load on returning read data, drop on transaction
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      out_data_d  = ram_rdata;
      out_pos_d   = PosW'(rd_pos_q);
      out_len_d   = LenW'(len_q);
      out_last_d  = rd_last_q;
    end else if (res_fire) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      enable_q    <= 1'b0;
      start_q     <= StartByteRst;
      cnt_q       <= '0;
      len_q       <= '0;
      chk_q       <= '0;
      sum_q       <= '0;
      emit_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      rd_pos_q    <= '0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_pos_q   <= '0;
      out_len_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      enable_q    <= enable_d;
      start_q     <= start_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      chk_q       <= chk_d;
      sum_q       <= sum_d;
      emit_idx_q  <= emit_idx_d;
      rd_pend_q   <= rd_pend_d;
      rd_pos_q    <= rd_pos_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_pos_q   <= out_pos_d;
      out_len_q   <= out_len_d;
      out_last_q  <= out_last_d;
    end
  end

  // Returning read data always finds the output register free
  `LPFR_ASSERT_NOW(a_rd_slot_free, clk_i, rst_ni, rd_pend_q, !out_valid_q)
  // Emitted positions stay inside the type-and-data bytes
  `LPFR_ASSERT_NOW(a_pos_range, clk_i, rst_ni, out_valid_q,
                   ({1'b0, out_pos_q} + (PosW+1)'(1)) < {1'b0, out_len_q})
  // An issued read is marked pending in the next cycle, as its data returns from the RAM
  `LPFR_ASSERT_NEXT(a_rd_lands, clk_i, rst_ni, rd_en, rd_pend_q)
  // No byte is written to the frame buffer during read-out
  `LPFR_ASSERT_NOW(a_no_wr_in_emit, clk_i, rst_ni, state_q == S_EMIT, !ram_we)

endmodule

// ----- test/length_prefixed_frame_receiver_tb.sv -----
`timescale 1ns / 100ps

module length_prefixed_frame_receiver_tb import lpfr_pkg::*; ();

  localparam int ClkPeriod  = 8;
  localparam int ResetTicks = 7;
  // Longest emit pass of a good frame plus margin
  localparam int Quiet      = 2 * MaxLen + 16;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 20;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic [PosW-1:0]  pos;
    logic [LenW-1:0]  len;
    logic             last;
  } frame_byte_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [ByteW-1:0]   data;
    bit                 typed;
    int                 n_typed;
    frame_byte_t        typed_res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lpfr_rx_if  rx_ch ();
  lpfr_res_if res_ch ();

  length_prefixed_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_ch),
    .res_o      (res_ch)
  );

  // Mirror of the configuration and the deframer state
  logic             rx_enabled;
  logic [ByteW-1:0] start_value;
  logic [6:0]       rcv_count;
  logic [LenW-1:0]  len_field;
  logic [ByteW-1:0] check_byte;
  logic [ByteW-1:0] byte_sum;
  logic [ByteW-1:0] frame_mem [BufferBytes];

  frame_byte_t fresh[$];
  frame_byte_t expected_bytes[$];

  int failures;
  int bytes_taken;
  int cycles;
  bit steady;
  bit hold_req;

  // Directed stimulus: bytes and register writes, typed results where obvious
  stim_row_t directed_rows [32] = '{
    '{ROW_BYTE, RegEnable,    8'hAA, 1, 0, '0},  // dropped: disabled after reset
    '{ROW_CFG,  RegEnable,    8'h01, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h00, 1, 0, '0},  // non-start while hunting
    '{ROW_BYTE, RegEnable,    8'hAA, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h01, 1, 0, '0},  // length too short
    '{ROW_BYTE, RegEnable,    8'hAA, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h3F, 1, 0, '0},  // length too long
    '{ROW_BYTE, RegEnable,    8'hAA, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'hAA, 1, 0, '0},  // rejected length, not a new start
    '{ROW_BYTE, RegEnable,    8'hAA, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h02, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'hFF, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h00, 1, 1, '{8'h00, 6'd0, 6'd2, 1'b1}},  // shortest frame
    '{ROW_BYTE, RegEnable,    8'hAA, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h02, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h00, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h00, 1, 0, '0},  // checksum mismatch
    '{ROW_BYTE, RegEnable,    8'hAA, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h03, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'hFF, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'hFF, 0, 0, '0},
    '{ROW_CFG,  RegEnable,    8'hFE, 0, 0, '0},  // disable mid-frame
    '{ROW_BYTE, RegEnable,    8'h01, 1, 0, '0},
    '{ROW_CFG,  RegEnable,    8'h01, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h01, 0, 0, '0},  // partial frame resumes
    '{ROW_CFG,  RegStartByte, 8'h00, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h00, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h02, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h7F, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'h80, 0, 0, '0},
    '{ROW_CFG,  RegStartByte, 8'hFF, 0, 0, '0},
    '{ROW_BYTE, RegEnable,    8'hFE, 1, 0, '0}
  };

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Advance the deframer by one received byte; leave any verified bytes in fresh
  task automatic deframe_byte(input logic [ByteW-1:0] b);
    frame_byte_t item;
    fresh.delete();
    if (!rx_enabled) return;
    if (rcv_count == 0) begin
      if (b == start_value) begin
        frame_mem[0] = b;
        rcv_count = 1;
      end
      return;
    end
    if (rcv_count == 1) begin
      if (b > MaxLen || b < MinLen) begin
        rcv_count = 0;
        len_field = 0;
      end else begin
        frame_mem[1] = b;
        len_field = b[LenW-1:0];
        rcv_count = 2;
      end
      return;
    end
    if (rcv_count == 2) begin
      frame_mem[2] = b;
      check_byte = b;
      byte_sum = 0;
      rcv_count = 3;
      return;
    end
    frame_mem[rcv_count] = b;
    byte_sum = byte_sum + b;
    rcv_count = rcv_count + 1;
    if (rcv_count < len_field + 2) return;
    // Frame complete: emit type and data only on a good checksum
    if ((byte_sum ^ 8'hFF) == check_byte) begin
      for (int k = 0; k < len_field - 1; k++) begin
        item.value = frame_mem[HeaderBytes + k];
        item.pos   = k[PosW-1:0];
        item.len   = len_field;
        item.last  = (k == len_field - 2);
        fresh.push_back(item);
      end
    end
    rcv_count = 0;
    len_field = 0;
  endtask

  // Offer one byte with random gaps; update the mirror once the transaction is taken
  task automatic offer_byte(input logic [ByteW-1:0] b, input bit predict);
    while (!steady && $urandom_range(99) < 38) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid    <= 1'b1;
    rx_ch.rx_value <= b;
    @(negedge clk_i);
    while (!rx_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    if (rx_enabled) bytes_taken++;
    deframe_byte(b);
    if (predict) foreach (fresh[i]) expected_bytes.push_back(fresh[i]);
  endtask

  // Drop valid, drain all expected bytes, then let the emit pass finish
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (Quiet) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegEnable) rx_enabled = data[0];
    else start_value = data[ByteW-1:0];
  endtask

  // Send a frame of the given length; cut > 0 truncates it to that many bytes
  task automatic send_frame(input int len, input bit bad_sum, input int cut);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] chk;
    logic [ByteW-1:0] wire_bytes[$];
    sum = 0;
    for (int i = 0; i < len - 1; i++) begin
      body.push_back(8'($urandom));
      sum = sum + body[i];
    end
    chk = ~sum;
    if (bad_sum) chk = chk ^ 8'($urandom_range(1, 255));
    wire_bytes = {start_value, 8'(len), chk, body};
    if (cut > 0 && cut < wire_bytes.size()) wire_bytes = wire_bytes[0:cut-1];
    foreach (wire_bytes[i]) offer_byte(wire_bytes[i], 1'b1);
  endtask

  // Check each result transaction against the oldest expected byte
  always @(negedge clk_i) begin : check_frame_bytes
    frame_byte_t want;
    frame_byte_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.out_value, res_ch.position, res_ch.frame_length, res_ch.last};
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte value=%h pos=%0d len=%0d last=%b",
                 $time, got.value, got.pos, got.len, got.last);
        failures++;
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected value=%h pos=%0d len=%0d last=%b",
                   $time, want.value, want.pos, want.len, want.last);
          $display("%0t:          actual   value=%h pos=%0d len=%0d last=%b",
                   $time, got.value, got.pos, got.len, got.last);
          failures++;
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        res_ch.ready <= 1'b0;
        for (int i = 0; i < HoldCycles; i++) @(posedge clk_i);
      end
      res_ch.ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    logic [ByteW-1:0] start_choices [4];
    int pick;
    bit first;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_value = '0;
    rx_enabled     = 1'b0;
    start_value    = StartByteRst;
    rcv_count      = 0;
    len_field      = 0;
    check_byte     = 0;
    byte_sum       = 0;
    failures       = 0;
    bytes_taken    = 0;
    cycles         = 0;
    steady         = 0;
    hold_req       = 0;
    repeat (ResetTicks) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        offer_byte(directed_rows[r].data, !directed_rows[r].typed);
        if (directed_rows[r].typed && directed_rows[r].n_typed == 1)
          expected_bytes.push_back(directed_rows[r].typed_res);
      end
    end

    // Random frames over several start byte settings
    start_choices = '{8'hAA, 8'($urandom), 8'h00, 8'hFF};
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      write_reg(RegStartByte, start_choices[phase]);
      write_reg(RegEnable, {7'($urandom), 1'b1});
      steady = (phase == 2);
      first = 1;
      bytes_taken = 0;
      while (bytes_taken < PhaseItems) begin
        pick = $urandom_range(99);
        if (phase == 1 && first) begin
          // Longest frame against a stalled result side, then keep offering
          hold_req = 1;
          send_frame(MaxLen, 0, 0);
          repeat (4) offer_byte(8'($urandom), 1'b1);
        end else if (pick < 60) begin
          send_frame($urandom_range(9) < 7 ? $urandom_range(MinLen, 8)
                                           : $urandom_range(MinLen, MaxLen), 0, 0);
        end else if (pick < 72) begin
          send_frame($urandom_range(MinLen, 10), 1, 0);
        end else if (pick < 82) begin
          offer_byte(start_value, 1'b1);
          offer_byte($urandom_range(1) ? 8'($urandom_range(MaxLen + 1, 255))
                                       : 8'($urandom_range(0, MinLen - 1)), 1'b1);
          repeat ($urandom_range(0, 2)) offer_byte(8'($urandom), 1'b1);
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4)) offer_byte(8'($urandom), 1'b1);
        end else if (pick < 95) begin
          send_frame($urandom_range(4, 10), 0, $urandom_range(2, 5));
        end else begin
          // Disable for a few bytes, then resume the partial frame
          settle();
          write_reg(RegEnable, {7'($urandom), 1'b0});
          repeat ($urandom_range(1, 3)) offer_byte(8'($urandom), 1'b1);
          settle();
          write_reg(RegEnable, {7'($urandom), 1'b1});
        end
        first = 0;
      end
    end
    steady = 0;

    settle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/lpfr_pkg.sv
design/lpfr_if.sv
design/lpfr_ram.sv
design/length_prefixed_frame_receiver.sv
test/length_prefixed_frame_receiver_tb.sv
